### design/mdfs_pkg.sv
package mdfs_pkg;

    localparam int GRID_MAX    = 16;
    localparam int COORD_W     = $clog2(GRID_MAX);
    localparam int STACK_DEPTH = 256;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = SP_W + 1;

    localparam int EXT_W = 5;
    localparam logic [EXT_W-1:0] EXT_MIN   = EXT_W'(2);
    localparam logic [EXT_W-1:0] EXT_MAX   = EXT_W'(GRID_MAX);
    localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(16);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_GRID_EXTENT = 1'b0;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_WEST  = 2'd2;
    localparam logic [1:0] DIR_EAST  = 2'd3;

    typedef struct packed {
        logic [3:0] pos_x;
        logic [3:0] pos_y;
        logic [3:0] wall_flags;
        logic [7:0] random_value;
    } t_step_in;

    typedef struct packed {
        logic       moved;
        logic       backtrack;
        logic [1:0] move_dir;
        logic [8:0] path_depth;
    } t_step_out;

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } t_state;

endpackage

### design/maze_dfs_explorer.sv
// A result is registered at the output at the clock edge after its input transfer,
// later only while the previous result is still held there.
// No new item is accepted until the current one commits, since the visited row, visited
// column and stack memories are read in the accept cycle and written back at commit.
// Reset: synchronous, active low; stack count and row/column valid bits clear and the
// extent goes to 16 at once; no clearing pass, so the block is ready right after reset.
module maze_dfs_explorer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mdfs_pkg::t_step_in                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mdfs_pkg::t_step_out                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mdfs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mdfs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mdfs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import mdfs_pkg::*;

    // Visited map stored twice: by row for west/east, by column for north/south.
    logic [GRID_MAX-1:0] row_mem [GRID_MAX];
    logic [GRID_MAX-1:0] col_mem [GRID_MAX];
    logic [1:0]          stack_mem [STACK_DEPTH];

    t_state              r_state, n_state;
    t_step_in            r_in;
    logic [GRID_MAX-1:0] r_row_q, r_col_q;
    logic [1:0]          r_top_q;
    logic [GRID_MAX-1:0] r_row_vld, r_col_vld;
    logic [CNT_W-1:0]    r_count;
    logic [EXT_W-1:0]    r_extent;
    t_step_out           r_out;
    logic                r_out_valid;

    logic                w_accept, w_commit, w_push, w_cfg_wr;
    logic [SP_W-1:0]     w_top_addr;
    logic [GRID_MAX-1:0] w_row, w_col, w_row_new, w_col_new;
    logic [EXT_W-1:0]    w_ext, w_xz, w_yz;
    logic [3:0]          w_allowed;
    logic [2:0]          w_num;
    logic [1:0]          w_pick, w_dir;
    t_step_out           w_res;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_top_addr = r_count[SP_W-1:0] - SP_W'(1);

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[APB_ADDR_W-1:2] == REG_GRID_EXTENT);
    assign prdata   = (paddr[APB_ADDR_W-1:2] == REG_GRID_EXTENT)
                      ? APB_DATA_W'(r_extent) : '0;

    always_comb begin
        n_state  = r_state;
        w_commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (!r_out_valid || i_out_ready) begin
                    w_commit = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // A row or column that was never written reads as all unvisited.
    assign w_row = r_row_vld[r_in.pos_y] ? r_row_q : '0;
    assign w_col = r_col_vld[r_in.pos_x] ? r_col_q : '0;
    assign w_row_new = w_row | (GRID_MAX'(1) << r_in.pos_x);
    assign w_col_new = w_col | (GRID_MAX'(1) << r_in.pos_y);

    assign w_ext = (r_extent < EXT_MIN) ? EXT_MIN :
                   (r_extent > EXT_MAX) ? EXT_MAX : r_extent;
    assign w_xz  = EXT_W'(r_in.pos_x);
    assign w_yz  = EXT_W'(r_in.pos_y);

    always_comb begin
        w_allowed = '0;
        if (r_count != CNT_W'(STACK_DEPTH)) begin
            w_allowed[DIR_NORTH] = !r_in.wall_flags[DIR_NORTH] && (r_in.pos_y != '0)
                && ((w_yz - EXT_W'(1)) < w_ext) && (w_xz < w_ext)
                && !w_col[r_in.pos_y - 4'd1];
            w_allowed[DIR_SOUTH] = !r_in.wall_flags[DIR_SOUTH]
                && ((w_yz + EXT_W'(1)) < w_ext) && (w_xz < w_ext)
                && !w_col[r_in.pos_y + 4'd1];
            w_allowed[DIR_WEST] = !r_in.wall_flags[DIR_WEST] && (r_in.pos_x != '0)
                && ((w_xz - EXT_W'(1)) < w_ext) && (w_yz < w_ext)
                && !w_row[r_in.pos_x - 4'd1];
            w_allowed[DIR_EAST] = !r_in.wall_flags[DIR_EAST]
                && ((w_xz + EXT_W'(1)) < w_ext) && (w_yz < w_ext)
                && !w_row[r_in.pos_x + 4'd1];
        end
    end

    assign w_num = 3'(w_allowed[0]) + 3'(w_allowed[1]) + 3'(w_allowed[2])
                 + 3'(w_allowed[3]);

    // Index into the allowed list: random value modulo the number of choices.
    // For three choices the base-4 digits are summed, since 4 is 1 modulo 3.
    always_comb begin
        logic [3:0] s4;
        logic [2:0] s2;
        s4 = 4'(r_in.random_value[1:0]) + 4'(r_in.random_value[3:2])
           + 4'(r_in.random_value[5:4]) + 4'(r_in.random_value[7:6]);
        s2 = 3'(s4[3:2]) + 3'(s4[1:0]);
        case (w_num)
            3'd2:    w_pick = {1'b0, r_in.random_value[0]};
            3'd3:    w_pick = (s2 >= 3'd6) ? 2'(s2 - 3'd6) :
                              (s2 >= 3'd3) ? 2'(s2 - 3'd3) : 2'(s2);
            3'd4:    w_pick = r_in.random_value[1:0];
            default: w_pick = 2'd0;
        endcase
    end

    always_comb begin
        logic [2:0] seen;
        logic       found;
        seen  = '0;
        found = 1'b0;
        w_dir = DIR_NORTH;
        for (int d = 0; d < 4; d++) begin
            if (w_allowed[d]) begin
                if (!found && seen == 3'(w_pick)) begin
                    w_dir = 2'(d);
                    found = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
    end

    assign w_push = w_commit && (w_num != '0);

    always_comb begin
        w_res = '0;
        if (w_num != '0) begin
            w_res.moved      = 1'b1;
            w_res.move_dir   = w_dir;
            w_res.path_depth = 9'(r_count + CNT_W'(1));
        end else if (r_count != '0) begin
            w_res.moved      = 1'b1;
            w_res.backtrack  = 1'b1;
            // Flipping the low bit turns north into south and west into east.
            w_res.move_dir   = r_top_q ^ 2'b01;
            w_res.path_depth = 9'(r_count - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in    <= i_in_data;
            r_row_q <= row_mem[i_in_data.pos_y];
            r_col_q <= col_mem[i_in_data.pos_x];
            r_top_q <= stack_mem[w_top_addr];
        end
        if (w_commit) begin
            row_mem[r_in.pos_y] <= w_row_new;
            col_mem[r_in.pos_x] <= w_col_new;
            r_out               <= w_res;
        end
        if (w_push) begin
            stack_mem[r_count[SP_W-1:0]] <= w_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_vld   <= '0;
            r_col_vld   <= '0;
            r_count     <= '0;
            r_extent    <= EXT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_extent <= pwdata[EXT_W-1:0];
            end
            if (w_commit) begin
                r_row_vld[r_in.pos_y] <= 1'b1;
                r_col_vld[r_in.pos_x] <= 1'b1;
                r_count               <= w_res.path_depth;
                r_out_valid           <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
